>>> rtl/core/terrain_slope_walkability_unit_defines.svh
// ----------------------------------------------------------------------------
// Terrain slope walkability unit - assertion macros
// Shared property wrappers for the checker; clocked on clk.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_SLOPE_WALKABILITY_UNIT_DEFINES_SVH
`define TERRAIN_SLOPE_WALKABILITY_UNIT_DEFINES_SVH

// Property checked outside reset
`define TSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also covers reset cycles
`define TSW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared constants, step codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int MAX_ROW_LEN_DEF = 1024;
  localparam int COORD_BITS_DEF  = 16;

  localparam int ROW_LEN_W  = 11;
  localparam int COS_W      = 16;
  localparam int SQ_W       = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  // cos is Q1.15, so the squared threshold carries 30 fraction bits
  localparam int COS_FRAC2  = 30;

  localparam logic [ROW_LEN_W-1:0]    ROW_LEN_RST = 11'd256;
  localparam logic signed [COS_W-1:0] COS_RST     = 16'sd23170;

  // register indexes
  localparam logic CFG_ROW_LEN = 1'b0;
  localparam logic CFG_COS     = 1'b1;

  typedef enum logic [4:0] {
    ST_NX0, ST_NX1, ST_NY0, ST_NY1, ST_NZ0, ST_NZ1, ST_NSAVE,
    ST_SQY0, ST_SQY1, ST_SQX0, ST_SQX1, ST_SQZ0, ST_SQZ1,
    ST_CSQ, ST_CSAVE, ST_R0, ST_R1, ST_R2, ST_R3, ST_EVAL
  } tsw_step_t;

  typedef struct packed {
    logic      accept;
    logic      fetch;
    logic      run;
    tsw_step_t step;
    logic      tri_sel;
    logic      res_load;
  } tsw_cmd_t;

  typedef struct packed {
    logic square;
  } tsw_stat_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/core/tsw_vert_if.sv
// ----------------------------------------------------------------------------
// tsw_vert_if
// Vertex input channel: valid/ready with one grid vertex per transfer.
// ----------------------------------------------------------------------------
interface tsw_vert_if import tsw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic signed [COORD_BITS-1:0] vert_z;
  logic                         grid_start;

  modport source (output valid, vert_x, vert_y, vert_z, grid_start, input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, grid_start, output ready);
endinterface

>>> rtl/core/tsw_res_if.sv
// ----------------------------------------------------------------------------
// tsw_res_if
// Result channel: valid/ready with one classified grid square per transfer.
// ----------------------------------------------------------------------------
interface tsw_res_if import tsw_pkg::*;;
  logic            valid;
  logic            ready;
  logic            walkable;
  logic            degenerate;
  logic [SQ_W-1:0] square_col;
  logic [SQ_W-1:0] square_row;

  modport source (output valid, walkable, degenerate, square_col, square_row, input ready);
  modport sink   (input valid, walkable, degenerate, square_col, square_row, output ready);
endinterface

>>> rtl/core/terrain_slope_walkability_unit.sv
// ----------------------------------------------------------------------------
// terrain_slope_walkability_unit
// Classifies heightmap grid squares as walkable from streamed vertices.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+------------------------------------------
//   vin      | in  | valid/ready    | vert_x, vert_y, vert_z, grid_start
//   res      | out | valid/ready    | walkable, degenerate, square_col, square_row
//   apb      | in  | psel/penable   | row_length @0x0, cos_threshold @0x4
//
// A vertex that closes no square goes through accept and the line buffer read
// only; one that closes a square adds 2 x 20 MAC steps and the hand-off.
// The shared multiply-accumulate runs 20 steps per triangle and sets the rate.
// Synchronous reset clears counters, held vertices and the result slot; the
// line buffer is not cleared. A held result stalls the sequencer in its done
// state, so no new vertex is taken while it waits.
// ----------------------------------------------------------------------------
module terrain_slope_walkability_unit import tsw_pkg::*; #(
  parameter int MAX_ROW_LEN = MAX_ROW_LEN_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  tsw_vert_if.sink              vin,
  tsw_res_if.source             res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ROW_LEN_W-1:0]    row_length;
  logic signed [COS_W-1:0] cos_threshold;
  logic                    cfg_wr;
  tsw_cmd_t                cmd;
  tsw_stat_t               stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length    <= ROW_LEN_RST;
      cos_threshold <= COS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_ROW_LEN: row_length    <= pwdata[ROW_LEN_W-1:0];
        CFG_COS:     cos_threshold <= pwdata[COS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_ROW_LEN: prdata = APB_DATA_W'(row_length);
      CFG_COS:     prdata = APB_DATA_W'(unsigned'(cos_threshold));
    endcase
  end

  tsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vin.valid),
    .in_ready  (vin.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsw_datapath #(
    .MAX_ROW_LEN (MAX_ROW_LEN),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .vert_x        (vin.vert_x),
    .vert_y        (vin.vert_y),
    .vert_z        (vin.vert_z),
    .grid_start    (vin.grid_start),
    .row_length    (row_length),
    .cos_threshold (cos_threshold),
    .walkable      (res.walkable),
    .degenerate    (res.degenerate),
    .square_col    (res.square_col),
    .square_row    (res.square_row)
  );

endmodule

>>> rtl/core/tsw_ctrl.sv
// ----------------------------------------------------------------------------
// tsw_ctrl
// Sequencer: accepts a vertex, waits for the line buffer read, steps the
// shared multiply-accumulate through both triangles and hands off the result.
// ----------------------------------------------------------------------------
module tsw_ctrl import tsw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tsw_stat_t stat,
  output tsw_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_RUN, S_DONE} state_t;

  state_t    state;
  tsw_step_t step;
  logic      tri_sel;
  logic      slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.accept   = in_ready && in_valid;
    cmd.fetch    = (state == S_FETCH);
    cmd.run      = (state == S_RUN);
    cmd.step     = step;
    cmd.tri_sel  = tri_sel;
    cmd.res_load = (state == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_NX0;
      tri_sel   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // raise on hand-off, drop once the sink takes the transfer
      if (cmd.res_load)                out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.accept) state <= S_FETCH;
        end
        S_FETCH: begin
          step    <= ST_NX0;
          tri_sel <= 1'b0;
          state   <= stat.square ? S_RUN : S_IDLE;
        end
        S_RUN: begin
          if (step == ST_EVAL) begin
            step    <= ST_NX0;
            tri_sel <= 1'b1;
            if (tri_sel) state <= S_DONE;
          end else begin
            step <= tsw_step_t'(step + 5'd1);
          end
        end
        S_DONE: begin
          if (slot_free) state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/tsw_datapath.sv
// ----------------------------------------------------------------------------
// tsw_datapath
// Line buffer, vertex registers, grid counters and one shared signed
// multiply-accumulate that builds normals, squared lengths and the threshold
// product for the exact slope test.
// ----------------------------------------------------------------------------
module tsw_datapath import tsw_pkg::*; #(
  parameter int MAX_ROW_LEN = MAX_ROW_LEN_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tsw_cmd_t                     cmd,
  output tsw_stat_t                    stat,
  input  logic signed [COORD_BITS-1:0] vert_x,
  input  logic signed [COORD_BITS-1:0] vert_y,
  input  logic signed [COORD_BITS-1:0] vert_z,
  input  logic                         grid_start,
  input  logic [ROW_LEN_W-1:0]         row_length,
  input  logic signed [COS_W-1:0]      cos_threshold,
  output logic                         walkable,
  output logic                         degenerate,
  output logic [SQ_W-1:0]              square_col,
  output logic [SQ_W-1:0]              square_row
);

  localparam int CB    = COORD_BITS;
  localparam int VW    = 3 * CB;
  localparam int CW    = $clog2(MAX_ROW_LEN);
  localparam int LW    = max_int($clog2(MAX_ROW_LEN + 1), ROW_LEN_W);
  localparam int D_W   = CB + 1;
  localparam int N_W   = 2 * CB + 3;
  localparam int MAG_W = 2 * CB + 2;
  localparam int CHUNK = CB + 2;
  localparam int HI_W  = MAG_W - CHUNK;
  localparam int L2_W  = 4 * CHUNK;
  localparam int C2_W  = 2 * COS_W - 1;
  localparam int A_W   = max_int(MAG_W, C2_W);
  localparam int B_W   = max_int(CHUNK, COS_W);
  localparam int P_W   = A_W + B_W + 2;
  localparam int ACC_W = L2_W + C2_W + 1;

  typedef enum logic [1:0] {M_NONE, M_CLR, M_ADD, M_SUB} mop_t;

  // line buffer
  logic [VW-1:0] lbuf [MAX_ROW_LEN];
  logic [VW-1:0] rd_q;

  logic [VW-1:0]   cur;
  logic [VW-1:0]   prev_v, far_left;
  logic [VW-1:0]   w_fl, w_nl, w_nr;
  logic [CW-1:0]   column_count;
  logic [SQ_W-1:0] row_count;
  logic [CW-1:0]   cc_eff;
  logic [SQ_W-1:0] rc_eff;
  logic [LW-1:0]   rl_e, len_eff, col_inc;
  logic            sq;
  logic [SQ_W-1:0] sq_col, sq_row;

  assign cur    = {vert_z, vert_y, vert_x};
  assign cc_eff = grid_start ? '0 : column_count;
  assign rc_eff = grid_start ? '0 : row_count;
  assign rl_e   = LW'(row_length);
  assign col_inc = LW'(cc_eff) + LW'(1);

  always_comb begin
    if (rl_e < LW'(2))                len_eff = LW'(2);
    else if (rl_e > LW'(MAX_ROW_LEN)) len_eff = LW'(MAX_ROW_LEN);
    else                              len_eff = rl_e;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_q         <= lbuf[cc_eff];
      lbuf[cc_eff] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_v       <= '0;
      far_left     <= '0;
      column_count <= '0;
      row_count    <= '0;
      sq           <= 1'b0;
    end else begin
      if (cmd.accept) begin
        prev_v <= cur;
        sq     <= (rc_eff != '0) && (cc_eff != '0);
        if (col_inc >= len_eff) begin
          column_count <= '0;
          row_count    <= rc_eff + 1'b1;
        end else begin
          column_count <= CW'(col_inc);
          row_count    <= rc_eff;
        end
      end
      if (cmd.fetch) far_left <= rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      w_fl   <= far_left;
      w_nl   <= prev_v;
      w_nr   <= cur;
      sq_col <= SQ_W'(cc_eff - 1'b1);
      sq_row <= rc_eff - 1'b1;
    end
  end

  assign stat.square = sq;

  // triangle corners and edge vectors, index 0 = x, 1 = y, 2 = z
  logic signed [CB-1:0]  p0 [3];
  logic signed [CB-1:0]  p1 [3];
  logic signed [CB-1:0]  p2 [3];
  logic signed [D_W-1:0] da [3];
  logic signed [D_W-1:0] db [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0[k] = w_fl[k*CB +: CB];
      p1[k] = cmd.tri_sel ? w_nr[k*CB +: CB] : w_nl[k*CB +: CB];
      p2[k] = cmd.tri_sel ? rd_q[k*CB +: CB] : w_nr[k*CB +: CB];
      da[k] = D_W'(p2[k]) - D_W'(p0[k]);
      db[k] = D_W'(p0[k]) - D_W'(p1[k]);
    end
  end

  logic signed [N_W-1:0]   n_q [3];
  logic [MAG_W-1:0]        nmag [3];
  logic [L2_W-1:0]         ny2, len2;
  logic [C2_W-1:0]         c2;
  logic signed [COS_W:0]   cos_x;
  logic [COS_W-1:0]        cmag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmag[k] = n_q[k][N_W-1] ? MAG_W'(-n_q[k]) : MAG_W'(n_q[k]);
    end
    cos_x = (COS_W+1)'(cos_threshold);
    cmag  = cos_x[COS_W] ? COS_W'(-cos_x) : COS_W'(cos_x);
  end

  // operand selection per step
  logic signed [A_W:0] opa;
  logic signed [B_W:0] opb;
  mop_t                mop;
  logic [1:0]          sh;
  logic [2:0]          st_n;
  logic                st_ny2, st_len2, st_c2, eval;

  function automatic logic signed [A_W:0] ua(input logic [A_W-1:0] v);
    return {1'b0, v};
  endfunction

  function automatic logic signed [B_W:0] ub(input logic [B_W-1:0] v);
    return {1'b0, v};
  endfunction

  always_comb begin
    opa     = '0;
    opb     = '0;
    mop     = M_NONE;
    sh      = 2'd0;
    st_n    = 3'b000;
    st_ny2  = 1'b0;
    st_len2 = 1'b0;
    st_c2   = 1'b0;
    eval    = 1'b0;
    case (cmd.step)
      ST_NX0: begin opa = (A_W+1)'(da[1]); opb = (B_W+1)'(db[2]); mop = M_CLR; end
      ST_NX1: begin opa = (A_W+1)'(da[2]); opb = (B_W+1)'(db[1]); mop = M_SUB; end
      ST_NY0: begin
        st_n[0] = 1'b1;
        opa = (A_W+1)'(da[2]); opb = (B_W+1)'(db[0]); mop = M_CLR;
      end
      ST_NY1: begin opa = (A_W+1)'(da[0]); opb = (B_W+1)'(db[2]); mop = M_SUB; end
      ST_NZ0: begin
        st_n[1] = 1'b1;
        opa = (A_W+1)'(da[0]); opb = (B_W+1)'(db[1]); mop = M_CLR;
      end
      ST_NZ1: begin opa = (A_W+1)'(da[1]); opb = (B_W+1)'(db[0]); mop = M_SUB; end
      ST_NSAVE: st_n[2] = 1'b1;
      // |n|^2 = |n| * lo + (|n| * hi) << CHUNK
      ST_SQY0: begin
        opa = ua(A_W'(nmag[1])); opb = ub(B_W'(nmag[1][CHUNK-1:0])); mop = M_CLR;
      end
      ST_SQY1: begin
        opa = ua(A_W'(nmag[1])); opb = ub(B_W'(nmag[1][MAG_W-1 -: HI_W]));
        mop = M_ADD; sh = 2'd1;
      end
      ST_SQX0: begin
        st_ny2 = 1'b1;
        opa = ua(A_W'(nmag[0])); opb = ub(B_W'(nmag[0][CHUNK-1:0])); mop = M_ADD;
      end
      ST_SQX1: begin
        opa = ua(A_W'(nmag[0])); opb = ub(B_W'(nmag[0][MAG_W-1 -: HI_W]));
        mop = M_ADD; sh = 2'd1;
      end
      ST_SQZ0: begin
        opa = ua(A_W'(nmag[2])); opb = ub(B_W'(nmag[2][CHUNK-1:0])); mop = M_ADD;
      end
      ST_SQZ1: begin
        opa = ua(A_W'(nmag[2])); opb = ub(B_W'(nmag[2][MAG_W-1 -: HI_W]));
        mop = M_ADD; sh = 2'd1;
      end
      ST_CSQ: begin
        st_len2 = 1'b1;
        opa = ua(A_W'(cmag)); opb = ub(B_W'(cmag)); mop = M_CLR;
      end
      ST_CSAVE: st_c2 = 1'b1;
      ST_R0: begin
        opa = ua(A_W'(c2)); opb = ub(B_W'(len2[0*CHUNK +: CHUNK])); mop = M_CLR;
      end
      ST_R1: begin
        opa = ua(A_W'(c2)); opb = ub(B_W'(len2[1*CHUNK +: CHUNK]));
        mop = M_ADD; sh = 2'd1;
      end
      ST_R2: begin
        opa = ua(A_W'(c2)); opb = ub(B_W'(len2[2*CHUNK +: CHUNK]));
        mop = M_ADD; sh = 2'd2;
      end
      ST_R3: begin
        opa = ua(A_W'(c2)); opb = ub(B_W'(len2[3*CHUNK +: CHUNK]));
        mop = M_ADD; sh = 2'd3;
      end
      ST_EVAL: eval = 1'b1;
      default: mop = M_NONE;
    endcase
  end

  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] prod_ext, term, acc;

  assign prod     = opa * opb;
  assign prod_ext = ACC_W'(prod);

  always_comb begin
    unique case (sh)
      2'd0: term = prod_ext;
      2'd1: term = prod_ext <<< CHUNK;
      2'd2: term = prod_ext <<< (2 * CHUNK);
      2'd3: term = prod_ext <<< (3 * CHUNK);
    endcase
  end

  // slope decision once acc holds c^2 * |n|^2
  logic [ACC_W-1:0] lhs, rhs;
  logic             n_zero, ny_neg, c_pos, c_neg, pass;

  always_comb begin
    lhs    = ACC_W'(ny2) << COS_FRAC2;
    rhs    = acc;
    n_zero = (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
    ny_neg = n_q[1][N_W-1];
    c_neg  = cos_threshold[COS_W-1];
    c_pos  = !c_neg && (cos_threshold != '0);
    pass   = !n_zero && (ny_neg ? (c_neg && (lhs <= rhs)) : (!c_pos || (lhs >= rhs)));
  end

  logic walk_acc, degen_acc;

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      unique case (mop)
        M_NONE: acc <= acc;
        M_CLR:  acc <= term;
        M_ADD:  acc <= acc + term;
        M_SUB:  acc <= acc - term;
      endcase
      for (int k = 0; k < 3; k++) begin
        if (st_n[k]) n_q[k] <= acc[N_W-1:0];
      end
      if (st_ny2)  ny2  <= acc[L2_W-1:0];
      if (st_len2) len2 <= acc[L2_W-1:0];
      if (st_c2)   c2   <= acc[C2_W-1:0];
      if (eval) begin
        walk_acc  <= walk_acc & pass;
        degen_acc <= degen_acc | n_zero;
      end
    end
    if (cmd.accept) begin
      walk_acc  <= 1'b1;
      degen_acc <= 1'b0;
    end
    if (cmd.res_load) begin
      walkable   <= walk_acc;
      degenerate <= degen_acc;
      square_col <= sq_col;
      square_row <= sq_row;
    end
  end

endmodule

>>> rtl/core/tsw_checker.sv
// ----------------------------------------------------------------------------
// tsw_checker
// Port-level checks for the walkability unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "terrain_slope_walkability_unit_defines.svh"

module tsw_checker import tsw_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            walkable,
  input logic            degenerate,
  input logic [SQ_W-1:0] square_col,
  input logic [SQ_W-1:0] square_row
);

  // a stalled result keeps its payload
  `TSW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(walkable) && $stable(degenerate) && $stable(square_col) && $stable(square_row), "result changed while stalled")

  // the sequencer is not ready again in the cycle after a transfer in
  `TSW_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "input taken back to back")

  // no result is raised in the cycle right after a transfer in
  `TSW_ASSERT(a_no_fast_result, $rose(out_valid) |-> !$past(in_valid && in_ready), "result too early")

  // reset leaves an empty result slot and a ready input
  `TSW_ASSERT_RST(a_reset_state, rst |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind terrain_slope_walkability_unit tsw_checker u_tsw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (vin.valid),
  .in_ready   (vin.ready),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .walkable   (res.walkable),
  .degenerate (res.degenerate),
  .square_col (res.square_col),
  .square_row (res.square_row)
);

>>> dv/terrain_slope_walkability_unit_tb.sv
// ----------------------------------------------------------------------------
// terrain_slope_walkability_unit_tb
// Streams terrain grids through the unit over several row length and slope
// threshold settings. A scoreboard keeps its own line buffer and grid
// position and checks each classified square against exact integer math.
// ----------------------------------------------------------------------------
module terrain_slope_walkability_unit_tb;
  import tsw_pkg::*;

  localparam int  ROW_MAX     = MAX_ROW_LEN_DEF;
  localparam int  CB          = COORD_BITS_DEF;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  DRAIN_WAIT  = 60;

  typedef struct {
    int x;
    int y;
    int z;
  } corner_t;

  class square_scoreboard;
    corner_t          line_buf[ROW_MAX];
    bit               line_valid[ROW_MAX];
    corner_t          last_corner;
    corner_t          far_left;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic [10:0]      row_len_reg;
    logic [15:0]      cos_reg;
    logic [3+2*SQ_W-1:0] pending_sq[$];
    int               mismatches;
    int               checked;
    int               walk_seen;
    int               degen_seen;

    function void clear();
      foreach (line_valid[i]) line_valid[i] = 0;
      last_corner = '{0, 0, 0};
      far_left    = '{0, 0, 0};
      col_cnt     = 0;
      row_cnt     = 0;
      row_len_reg = ROW_LEN_RST;
      cos_reg     = COS_RST;
      mismatches  = 0;
      checked     = 0;
      walk_seen   = 0;
      degen_seen  = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == CFG_ROW_LEN) row_len_reg = value[10:0];
      else                    cos_reg     = value[15:0];
    endfunction

    function int unsigned eff_len();
      if (row_len_reg < 2) return 2;
      if (row_len_reg > ROW_MAX) return ROW_MAX;
      return row_len_reg;
    endfunction

    function int unsigned cur_col();
      return (col_cnt < ROW_MAX) ? col_cnt : 0;
    endfunction

    // True when a vertex without grid_start would read a never-written entry
    function bit needs_restart();
      return row_cnt >= 1 && !line_valid[cur_col()];
    endfunction

    function logic [127:0] square_mag(longint v);
      logic [127:0] m;
      m = (v < 0) ? -v : v;
      return m * m;
    endfunction

    function bit slope_ok(corner_t p0, corner_t p1, corner_t p2, int c, inout bit degen);
      longint ax, ay, az, bx, by, bz, nx, ny, nz;
      logic [127:0] ny2, len2, lhs, rhs, c2;
      ax = p2.x - p0.x; ay = p2.y - p0.y; az = p2.z - p0.z;
      bx = p0.x - p1.x; by = p0.y - p1.y; bz = p0.z - p1.z;
      nx = ay * bz - az * by;
      ny = az * bx - ax * bz;
      nz = ax * by - ay * bx;
      if (nx == 0 && ny == 0 && nz == 0) begin
        degen = 1;
        return 0;
      end
      if (ny >= 0 && c <= 0) return 1;
      if (ny < 0 && c >= 0) return 0;
      ny2  = square_mag(ny);
      len2 = square_mag(nx) + ny2 + square_mag(nz);
      c2   = square_mag(c);
      lhs  = ny2 << COS_FRAC2;
      rhs  = len2 * c2;
      return (ny >= 0) ? (lhs >= rhs) : (lhs <= rhs);
    endfunction

    function void note_vertex(logic [CB-1:0] vx, logic [CB-1:0] vy, logic [CB-1:0] vz,
                              logic gs);
      corner_t     cur, far_right;
      int unsigned col;
      int          c;
      bit          degen, ok1, ok2;
      cur = '{int'($signed(vx)), int'($signed(vy)), int'($signed(vz))};
      if (gs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      col = cur_col();
      far_right = line_buf[col];
      if (row_cnt >= 1 && col >= 1) begin
        c     = int'($signed(cos_reg));
        degen = 0;
        ok1   = slope_ok(far_left, last_corner, cur, c, degen);
        ok2   = slope_ok(far_left, cur, far_right, c, degen);
        pending_sq.insert(pending_sq.size(),
                          {ok1 && ok2, degen, 1'b0, SQ_W'(col - 1), SQ_W'(row_cnt - 1)});
      end
      far_left        = far_right;
      line_buf[col]   = cur;
      line_valid[col] = 1;
      last_corner     = cur;
      if (col + 1 >= eff_len()) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1) % 1024;
      end else begin
        col_cnt = col + 1;
      end
    endfunction

    function void check_square(logic walk, logic degen, logic [SQ_W-1:0] scol,
                               logic [SQ_W-1:0] srow);
      logic [3+2*SQ_W-1:0] want;
      if (pending_sq.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected square col %0d row %0d walk %0b degen %0b",
                   scol, srow, walk, degen);
        return;
      end
      want = pending_sq.pop_front();
      checked++;
      walk_seen  += walk;
      degen_seen += degen;
      if (want[2*SQ_W+2] !== walk || want[2*SQ_W+1] !== degen ||
          want[2*SQ_W-1:SQ_W] !== scol || want[SQ_W-1:0] !== srow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("square mismatch: want walk %0b degen %0b col %0d row %0d, got %0b %0b %0d %0d",
                   want[2*SQ_W+2], want[2*SQ_W+1], want[2*SQ_W-1:SQ_W], want[SQ_W-1:0],
                   walk, degen, scol, srow);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tsw_vert_if vin_if ();
  tsw_res_if  res_if ();

  terrain_slope_walkability_unit dut (
    .clk     (clk),
    .rst     (rst),
    .vin     (vin_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  square_scoreboard sb;
  bit               idle_on;
  int               sink_hold;
  int               cycles = 0;
  int               vertices_sent;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("terrain_slope_walkability_unit_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && vin_if.valid && vin_if.ready)
      sb.note_vertex(vin_if.vert_x, vin_if.vert_y, vin_if.vert_z, vin_if.grid_start);
    if (!rst && res_if.valid && res_if.ready)
      sb.check_square(res_if.walkable, res_if.degenerate, res_if.square_col,
                      res_if.square_row);
  end

  // Result side: random back-pressure while idling is enabled
  initial begin
    res_if.ready = 0;
    sink_hold    = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        res_if.ready = 0;
      end else begin
        res_if.ready = 1;
        if (idle_on && $urandom_range(0, 7) == 0) sink_hold = gap_len();
      end
    end
  end

  task automatic send_vertex(int x, int y, int z, bit gs);
    int gap;
    gap = idle_on ? gap_len() : 0;
    repeat (gap) @(negedge clk);
    vin_if.vert_x     = CB'(x);
    vin_if.vert_y     = CB'(y);
    vin_if.vert_z     = CB'(z);
    vin_if.grid_start = gs;
    vin_if.valid      = 1;
    do @(posedge clk); while (!vin_if.ready);
    @(negedge clk);
    vin_if.valid = 0;
    vertices_sent++;
  endtask

  task automatic apb_write(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1;
    penable = 0;
    pwrite  = 1;
    paddr   = CFG_ADDR_W'(int'(idx) * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    = 0;
    penable = 0;
    pwrite  = 0;
  endtask

  task automatic drain();
    while (sb.pending_sq.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Sloped-grid terrain with random heights, some pure noise, rare restarts
  task automatic random_terrain(int count, int step, int amp, bit allow_restart);
    int x, y, z;
    bit gs;
    for (int i = 0; i < count; i++) begin
      gs = allow_restart && ($urandom_range(0, 99) == 0);
      if (sb.needs_restart()) gs = 1;
      if ($urandom_range(0, 99) < 12) begin
        x = $urandom; y = $urandom; z = $urandom;
      end else begin
        x = int'(gs ? 0 : sb.cur_col()) * step;
        z = int'(gs ? 0 : sb.row_cnt) * step;
        y = $urandom_range(0, 2 * amp) - amp;
      end
      send_vertex(x, y, z, gs);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst               = 1;
    idle_on           = 0;
    vertices_sent     = 0;
    psel              = 0;
    penable           = 0;
    pwrite            = 0;
    paddr             = '0;
    pwdata            = '0;
    vin_if.valid      = 0;
    vin_if.vert_x     = '0;
    vin_if.vert_y     = '0;
    vin_if.vert_z     = '0;
    vin_if.grid_start = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: flat, steep, degenerate, extreme coordinates, short rows
    apb_write(CFG_ROW_LEN, 3);
    apb_write(CFG_COS, 32'(COS_RST));
    send_vertex(0, 0, 0, 1);
    send_vertex(256, 0, 0, 0);
    send_vertex(512, 0, 0, 0);
    send_vertex(0, 0, 256, 0);
    send_vertex(256, 0, 256, 0);
    send_vertex(512, 32767, 256, 0);
    send_vertex(0, -32768, 512, 0);
    send_vertex(-32768, 32767, -32768, 0);
    send_vertex(32767, -32768, 32767, 0);
    // all corners equal: zero normals
    send_vertex(100, 100, 100, 1);
    send_vertex(100, 100, 100, 0);
    send_vertex(100, 100, 100, 0);
    send_vertex(100, 100, 100, 0);
    send_vertex(100, 100, 100, 0);
    send_vertex(100, 100, 100, 0);
    // mirrored grid turns normals downward
    send_vertex(0, 0, 0, 1);
    send_vertex(-256, 0, 0, 0);
    send_vertex(-512, 0, 0, 0);
    send_vertex(0, 10, 256, 0);
    send_vertex(-256, 20, 256, 0);
    drain();
    // shrink mid-row: column past the new end closes the row
    send_vertex(-512, 30, 256, 0);
    send_vertex(0, 0, 512, 0);
    drain();
    apb_write(CFG_ROW_LEN, 2);
    send_vertex(-256, 0, 512, 0);
    send_vertex(0, 0, 768, 0);
    send_vertex(-256, 5, 768, 0);
    drain();

    idle_on = 1;
    apb_write(CFG_ROW_LEN, 8);
    apb_write(CFG_COS, 32'h8000);
    random_terrain(60, 256, 200, 1);
    drain();
    apb_write(CFG_COS, 32'h7FFF);
    random_terrain(60, 256, 30, 1);
    drain();
    apb_write(CFG_ROW_LEN, 5);
    apb_write(CFG_COS, 0);
    random_terrain(60, 256, 400, 1);
    drain();
    idle_on = 0;
    apb_write(CFG_COS, 32'($urandom_range(0, 65535)));
    random_terrain(60, 128, 300, 1);
    drain();
    idle_on = 1;
    apb_write(CFG_ROW_LEN, 16);
    apb_write(CFG_COS, 32'hC000);
    random_terrain(60, 256, 500, 1);
    drain();
    apb_write(CFG_COS, 32'(COS_RST));
    apb_write(CFG_ROW_LEN, 37);
    random_terrain(60, 512, 300, 1);
    drain();

    // row length below range acts as two
    idle_on = 0;
    apb_write(CFG_ROW_LEN, 0);
    apb_write(CFG_COS, 32'($urandom_range(0, 65535)));
    random_terrain(100, 256, 300, 0);
    drain();
    // row length above range acts as the buffer depth
    apb_write(CFG_ROW_LEN, 2047);
    apb_write(CFG_COS, 32'(COS_RST));
    random_terrain(1040, 32, 100, 0);
    drain();

    $display("sent %0d vertices, checked %0d squares (%0d walkable, %0d degenerate)",
             vertices_sent, sb.checked, sb.walk_seen, sb.degen_seen);
    $display("mismatches %0d, squares still outstanding %0d", sb.mismatches,
             sb.pending_sq.size());
    if (sb.mismatches == 0 && sb.pending_sq.size() == 0) begin
      $display("terrain_slope_walkability_unit_tb: PASS");
    end else begin
      $display("terrain_slope_walkability_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
